>>> rtl/wpf_pkg.sv
// Package for the waypoint path follower: shared widths, field layout, codes and
// the request type of the multiply-accumulate unit. No dependencies.
package wpf_pkg;

  localparam int MAX_WAYPOINTS_DEF = 64;

  // Stream payload widths (fields packed from bit 0 up, padded to whole bytes).
  localparam int IN_TDATA_W  = 144;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 176;
  localparam int OUT_USED_W  = 169;

  // Configuration port.
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_LOOP_ENABLE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] CFG_ARRIVAL_THR = 1'b1;
  localparam logic [15:0] ARRIVAL_THR_RESET = 16'd6;

  // Item kinds carried on in_tuser.
  localparam logic [1:0] MODE_ADD_WAYPOINT = 2'd0;
  localparam logic [1:0] MODE_SET_POSITION = 2'd1;
  localparam logic [1:0] MODE_ADVANCE      = 2'd2;

  // Arithmetic widths: axis differences are 33-bit signed, magnitudes 33-bit,
  // sums of squares and scaled moves stay below 2^66.
  localparam int MAG_W   = 33;
  localparam int ACC_W   = 66;
  localparam int CHUNK_W = 16;

  typedef struct packed {
    logic             go;
    logic             clr;
    logic [MAG_W-1:0] a;
    logic [MAG_W-1:0] b;
  } mac_req_t;

endpackage

>>> rtl/waypoint_path_follower_core.sv
// Waypoint path follower: one item in work at a time, in_tready high only while idle.
// Adding a waypoint, setting the position, the unused kind or an advance with nothing to
// aim at go straight to the final state, which registers the result once the output is
// free; other advances square, root and compare, then finish within the threshold, snap
// onto the target or run a full move. The next item is taken the cycle after the result is
// registered. Synchronous active-low reset clears control, configuration, counters and
// position, not the table, working or result data. Depends on wpf_pkg, wpf_ram and wpf_mac.
module waypoint_path_follower_core #(
  parameter int MAX_WAYPOINTS = wpf_pkg::MAX_WAYPOINTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Configuration: index 0 loop_enable, index 1 arrival_threshold.
  input  logic                            cfg_wr_en,
  input  logic [wpf_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [wpf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata: coord_x[31:0], coord_y[63:32], coord_z[95:64], speed[127:96],
  // delta_time[143:128].
  input  logic [wpf_pkg::IN_TDATA_W-1:0]  in_tdata,
  // in_tuser: mode[1:0].
  input  logic [wpf_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata: pos_x[31:0], pos_y[63:32], pos_z[95:64], target_index[102:96],
  // finished[103], loop_count[135:104], tick_count[167:136], status[168], zeros above.
  output logic [wpf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  localparam int AW = $clog2(MAX_WAYPOINTS + 1);
  localparam int IW = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;
  localparam int MW = wpf_pkg::MAG_W;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_SQ, S_SQW, S_SQRT, S_CMP, S_STEPW, S_MV, S_MVW, S_DIV, S_APPLY, S_FIN
  } state_t;

  state_t            state_r;
  logic              loop_en_r;
  logic [15:0]       thr_r;
  logic [AW-1:0]     total_r;
  logic [AW-1:0]     aim_r;
  logic [31:0]       pos_r [3];
  logic              done_r;
  logic [31:0]       wrap_r;
  logic [31:0]       tick_r;
  logic              status_r;
  logic [31:0]       speed_r;
  logic [15:0]       dt_r;
  logic signed [MW-1:0] d_r [3];
  logic [1:0]        axis_r;
  logic [wpf_pkg::ACC_W-1:0] sq_r;
  logic [35:0]       rem_r;
  logic [MW-1:0]     root_r;
  logic [MW-1:0]     quo_r;
  logic [5:0]        cnt_r;
  logic [31:0]       step_r;
  logic              out_valid_r;
  logic [wpf_pkg::OUT_TDATA_W-1:0] out_data_r;

  // Waypoint table, x in the low word.
  logic              ram_we;
  logic [95:0]       ram_rd;
  logic [31:0]       wp [3];

  wpf_ram #(
    .WIDTH (96),
    .DEPTH (MAX_WAYPOINTS),
    .ADDR_W(IW)
  ) u_ram (
    .clk    (clk),
    .wr_en  (ram_we),
    .wr_addr(total_r[IW-1:0]),
    .wr_data(in_tdata[95:0]),
    .rd_addr(aim_r[IW-1:0]),
    .rd_data(ram_rd)
  );

  assign wp[0] = ram_rd[31:0];
  assign wp[1] = ram_rd[63:32];
  assign wp[2] = ram_rd[95:64];

  logic in_acc;
  assign in_acc    = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign ram_we    = in_acc && (in_tuser == wpf_pkg::MODE_ADD_WAYPOINT)
                     && (total_r < AW'(MAX_WAYPOINTS));

  // Magnitude of the difference on the current axis.
  logic signed [MW-1:0] d_cur;
  logic [MW-1:0]        mag_cur;
  assign d_cur   = d_r[axis_r];
  assign mag_cur = d_cur[MW-1] ? MW'(-d_cur) : MW'(d_cur);

  // Shared multiply-accumulate unit.
  wpf_pkg::mac_req_t            mac_req;
  logic                         mac_done;
  logic [wpf_pkg::ACC_W-1:0]    mac_acc;
  logic                         arrived;

  assign arrived = root_r <= {{(MW-16){1'b0}}, thr_r};

  always_comb begin
    mac_req     = '0;
    mac_req.a   = mag_cur;
    mac_req.b   = mag_cur;
    unique case (state_r)
      S_SQ: begin
        mac_req.go  = 1'b1;
        mac_req.clr = (axis_r == 2'd0);
      end
      S_CMP: begin
        mac_req.go  = !arrived;
        mac_req.clr = 1'b1;
        mac_req.a   = {1'b0, speed_r};
        mac_req.b   = {17'b0, dt_r};
      end
      S_MV: begin
        mac_req.go  = 1'b1;
        mac_req.clr = 1'b1;
        mac_req.b   = {1'b0, step_r};
      end
      default: ;
    endcase
  end

  wpf_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mac_req),
    .done (mac_done),
    .acc  (mac_acc)
  );

  // Shared trial subtractor: the square root and the divisions take one bit a cycle.
  logic [35:0] sub_a;
  logic [35:0] sub_b;
  logic [36:0] sub_full;
  logic        sub_ge;
  always_comb begin
    if (state_r == S_SQRT) begin
      sub_a = {rem_r[33:0], sq_r[65:64]};
      sub_b = {1'b0, root_r, 2'b01};
    end else begin
      sub_a = {rem_r[34:0], quo_r[MW-1]};
      sub_b = {3'b0, root_r};
    end
  end
  assign sub_full = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_full[36];

  // Move to the next waypoint, wrapping when looping is enabled.
  logic [AW-1:0] nt_aim;
  logic          nt_past;
  assign nt_aim  = aim_r + AW'(1);
  assign nt_past = nt_aim >= total_r;

  logic [31:0] step_w;
  assign step_w = mac_acc[47:16];

  logic [AW+6:0] aim_ext;
  assign aim_ext = {7'b0, aim_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loop_en_r   <= 1'b0;
      thr_r       <= wpf_pkg::ARRIVAL_THR_RESET;
      total_r     <= '0;
      aim_r       <= '0;
      pos_r[0]    <= '0;
      pos_r[1]    <= '0;
      pos_r[2]    <= '0;
      done_r      <= 1'b0;
      wrap_r      <= '0;
      tick_r      <= '0;
      status_r    <= 1'b0;
      out_valid_r <= 1'b0;
      axis_r      <= 2'd0;
      cnt_r       <= '0;
    end else begin
      if (cfg_wr_en) begin
        unique case (cfg_index)
          wpf_pkg::CFG_LOOP_ENABLE: loop_en_r <= cfg_wdata[0];
          wpf_pkg::CFG_ARRIVAL_THR: thr_r     <= cfg_wdata[15:0];
          default: ;
        endcase
      end
      // In the final state the result register is reloaded instead.
      if (out_valid_r && out_tready && (state_r != S_FIN)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            // Only a dropped waypoint reports a non-zero status.
            status_r <= (in_tuser == wpf_pkg::MODE_ADD_WAYPOINT) && !ram_we;
            speed_r  <= in_tdata[127:96];
            dt_r     <= in_tdata[143:128];
            if (in_tuser == wpf_pkg::MODE_ADD_WAYPOINT) begin
              if (ram_we) begin
                total_r <= total_r + AW'(1);
              end
            end else if (in_tuser == wpf_pkg::MODE_SET_POSITION) begin
              pos_r[0] <= in_tdata[31:0];
              pos_r[1] <= in_tdata[63:32];
              pos_r[2] <= in_tdata[95:64];
            end else if (in_tuser == wpf_pkg::MODE_ADVANCE) begin
              tick_r <= tick_r + 32'd1;
              if (aim_r >= total_r) begin
                done_r <= 1'b1;
              end
            end
            if ((in_tuser == wpf_pkg::MODE_ADVANCE) && (aim_r < total_r)) begin
              state_r <= S_RD;
            end else begin
              state_r <= S_FIN;
            end
          end
        end
        S_RD: begin
          // The table entry aimed at was read on the accepting edge.
          d_r[0]  <= $signed({wp[0][31], wp[0]}) - $signed({pos_r[0][31], pos_r[0]});
          d_r[1]  <= $signed({wp[1][31], wp[1]}) - $signed({pos_r[1][31], pos_r[1]});
          d_r[2]  <= $signed({wp[2][31], wp[2]}) - $signed({pos_r[2][31], pos_r[2]});
          axis_r  <= 2'd0;
          state_r <= S_SQ;
        end
        S_SQ: begin
          state_r <= S_SQW;
        end
        S_SQW: begin
          if (mac_done) begin
            if (axis_r == 2'd2) begin
              sq_r    <= mac_acc;
              rem_r   <= '0;
              root_r  <= '0;
              cnt_r   <= '0;
              state_r <= S_SQRT;
            end else begin
              axis_r  <= axis_r + 2'd1;
              state_r <= S_SQ;
            end
          end
        end
        S_SQRT: begin
          rem_r  <= sub_ge ? sub_full[35:0] : sub_a;
          root_r <= {root_r[MW-2:0], sub_ge};
          sq_r   <= {sq_r[wpf_pkg::ACC_W-3:0], 2'b00};
          cnt_r  <= cnt_r + 6'd1;
          if (cnt_r == 6'(MW - 1)) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          // root_r now holds the distance to the target.
          if (arrived) begin
            if (nt_past && loop_en_r) begin
              aim_r  <= '0;
              wrap_r <= wrap_r + 32'd1;
              done_r <= 1'b0;
            end else begin
              aim_r <= nt_aim;
              if (nt_past) begin
                done_r <= 1'b1;
              end
            end
            state_r <= S_FIN;
          end else begin
            state_r <= S_STEPW;
          end
        end
        S_STEPW: begin
          if (mac_done) begin
            if ({1'b0, step_w} >= root_r) begin
              pos_r[0] <= wp[0];
              pos_r[1] <= wp[1];
              pos_r[2] <= wp[2];
              if (nt_past && loop_en_r) begin
                aim_r  <= '0;
                wrap_r <= wrap_r + 32'd1;
                done_r <= 1'b0;
              end else begin
                aim_r <= nt_aim;
                if (nt_past) begin
                  done_r <= 1'b1;
                end
              end
              state_r <= S_FIN;
            end else begin
              step_r  <= step_w;
              axis_r  <= 2'd0;
              state_r <= S_MV;
            end
          end
        end
        S_MV: begin
          state_r <= S_MVW;
        end
        S_MVW: begin
          if (mac_done) begin
            // The quotient fits 33 bits, so the top part of the dividend is below the
            // divisor and can seed the remainder.
            rem_r   <= {3'b0, mac_acc[65:33]};
            quo_r   <= mac_acc[32:0];
            cnt_r   <= '0;
            state_r <= S_DIV;
          end
        end
        S_DIV: begin
          rem_r <= sub_ge ? sub_full[35:0] : sub_a;
          quo_r <= {quo_r[MW-2:0], sub_ge};
          cnt_r <= cnt_r + 6'd1;
          if (cnt_r == 6'(MW - 1)) begin
            state_r <= S_APPLY;
          end
        end
        S_APPLY: begin
          pos_r[axis_r] <= d_cur[MW-1] ? pos_r[axis_r] - quo_r[31:0]
                                       : pos_r[axis_r] + quo_r[31:0];
          if (axis_r == 2'd2) begin
            done_r  <= 1'b0;
            state_r <= S_FIN;
          end else begin
            axis_r  <= axis_r + 2'd1;
            state_r <= S_MV;
          end
        end
        S_FIN: begin
          if (!out_valid_r || out_tready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= {7'b0, status_r, tick_r, wrap_r, done_r, aim_ext[6:0],
                            pos_r[2], pos_r[1], pos_r[0]};
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

>>> rtl/wpf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module wpf_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 64,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/wpf_mac.sv
// Shared multiply-accumulate unit: a 33 x 16 multiplier worked over three chunks
// of the second operand, with a registered product. Depends on wpf_pkg.
module wpf_mac (
  input  logic                    clk,
  input  logic                    rst_n,
  input  wpf_pkg::mac_req_t       req,
  output logic                    done,
  output logic [wpf_pkg::ACC_W-1:0] acc
);

  logic [wpf_pkg::MAG_W-1:0]   a_r;
  logic [wpf_pkg::MAG_W-1:0]   b_r;
  logic [1:0]                  cnt_r;
  logic                        run_r;
  logic                        pv_r;
  logic [1:0]                  sh_r;
  logic [wpf_pkg::MAG_W+wpf_pkg::CHUNK_W-1:0] prod_r;
  logic [wpf_pkg::ACC_W-1:0]   acc_r;
  logic                        done_r;
  logic [wpf_pkg::CHUNK_W-1:0] chunk;
  logic [wpf_pkg::ACC_W-1:0]   addend;

  always_comb begin
    unique case (cnt_r)
      2'd0:    chunk = b_r[15:0];
      2'd1:    chunk = b_r[31:16];
      default: chunk = {15'b0, b_r[32]};
    endcase
  end

  assign addend = {{(wpf_pkg::ACC_W-wpf_pkg::MAG_W-wpf_pkg::CHUNK_W){1'b0}}, prod_r}
                  << {sh_r, 4'b0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      pv_r   <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      // The last chunk has been added once the top partial product is taken in.
      done_r <= pv_r && (sh_r == 2'd2);
      pv_r   <= run_r;
      if (req.go) begin
        a_r   <= req.a;
        b_r   <= req.b;
        cnt_r <= 2'd0;
        run_r <= 1'b1;
        if (req.clr) begin
          acc_r <= '0;
        end
      end else if (run_r) begin
        prod_r <= a_r * chunk;
        sh_r   <= cnt_r;
        cnt_r  <= cnt_r + 2'd1;
        if (cnt_r == 2'd2) begin
          run_r <= 1'b0;
        end
      end
      if (pv_r) begin
        acc_r <= acc_r + addend;
      end
    end
  end

  assign done = done_r;
  assign acc  = acc_r;

endmodule

>>> rtl/wpf_chk.sv
// Port-level checker for the waypoint path follower, bound to the top level.
// Depends on wpf_pkg and waypoint_path_follower_core.
module wpf_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [wpf_pkg::OUT_TDATA_W-1:0] out_tdata
);

  // A result that is not taken holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Only one item is in work at a time.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item accepted while busy");

  // Reset leaves no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Padding above the status bit stays zero.
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[wpf_pkg::OUT_TDATA_W-1:wpf_pkg::OUT_USED_W] == '0)
    else $error("padding bits set");

endmodule

bind waypoint_path_follower_core wpf_chk u_wpf_chk (.*);
